@@ hw/rtl/tat_pkg.sv @@
// Shared types and command codes for the target angle tracker.
package tat_pkg;

    // Plate index width; the plate count never exceeds eight.
    localparam int PIDX_W = 3;
    // Iteration counter width, large enough for the CORDIC step count.
    localparam int ITER_W = 5;
    localparam int CORDIC_STEPS = 24;

    typedef logic [4:0] dp_op_t;

    localparam dp_op_t OP_NOP     = 5'd0;
    localparam dp_op_t OP_LOAD    = 5'd1;
    localparam dp_op_t OP_COEF    = 5'd2;
    localparam dp_op_t OP_ROT0    = 5'd3;
    localparam dp_op_t OP_ROT1    = 5'd4;
    localparam dp_op_t OP_ROT2    = 5'd5;
    localparam dp_op_t OP_ROT3    = 5'd6;
    localparam dp_op_t OP_ROT4    = 5'd7;
    localparam dp_op_t OP_ROT5    = 5'd8;
    localparam dp_op_t OP_DIF     = 5'd9;
    localparam dp_op_t OP_SQ0     = 5'd10;
    localparam dp_op_t OP_SQ1     = 5'd11;
    localparam dp_op_t OP_SQ2     = 5'd12;
    localparam dp_op_t OP_THR     = 5'd13;
    localparam dp_op_t OP_BEST    = 5'd14;
    localparam dp_op_t OP_OFS     = 5'd15;
    localparam dp_op_t OP_VINIT   = 5'd16;
    localparam dp_op_t OP_VSTEP   = 5'd17;
    localparam dp_op_t OP_UNWRAP  = 5'd18;
    localparam dp_op_t OP_RESTART = 5'd19;
    localparam dp_op_t OP_EMIT    = 5'd20;

    // Command from the controller to the datapath.
    typedef struct packed {
        dp_op_t              op;
        logic [PIDX_W-1:0]   k;
        logic                coef_neg;
        logic                rot_src_prev;
        logic                rot_dst_cand;
        logic                ref_cand;
        logic [ITER_W-1:0]   iter;
        logic                first;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                req_restart;
        logic                hist_valid;
        logic                dir_active;
        logic                dir_cw;
        logic                offset_nz;
        logic                jump;
        logic [PIDX_W-1:0]   offset;
        logic [PIDX_W-1:0]   best;
    } dp_status_t;

endpackage

@@ hw/rtl/tat_stream_if.sv @@
// Valid/ready channel interfaces for tracker requests and results.
interface tat_req_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic [14:0]                   jump_radius;

    modport source (output valid, req_type, pos_x, pos_y, jump_radius, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, jump_radius, output ready);
endinterface

interface tat_res_if #(parameter int ANGLE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] track_angle;
    logic [2:0]                    plate_offset;
    logic                          jump_seen;

    modport source (output valid, track_angle, plate_offset, jump_seen, input ready);
    modport sink (input valid, track_angle, plate_offset, jump_seen, output ready);
endinterface

@@ hw/rtl/tat_datapath.sv @@
// Datapath of the tracker: shared multiplier, rotations, distances, CORDIC and unwrap.
module tat_datapath #(
    parameter int PLATE_COUNT = 5,
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tat_pkg::dp_cmd_t              cmd,
    output tat_pkg::dp_status_t           status,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_wr_data,
    input  logic                          req_type,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic [14:0]                   jump_radius,
    output logic signed [ANGLE_WIDTH-1:0] track_angle,
    output logic [2:0]                    plate_offset,
    output logic                          jump_seen
);
    import tat_pkg::*;

    localparam int C  = COORD_WIDTH;
    localparam int AN = ANGLE_WIDTH;
    localparam int PW = C + 33;          // product width
    localparam int AW = C + 34;          // accumulator width
    localparam int VW = C + 11;          // vectoring CORDIC width
    localparam int TAB_DEPTH = 1 << PIDX_W;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

    localparam logic signed [C-1:0]  CMAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0]  CMIN = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [AN-1:0] AMAX = {1'b0, {(AN-1){1'b1}}};
    localparam logic signed [AN-1:0] AMIN = {1'b1, {(AN-1){1'b0}}};
    localparam logic signed [AW-1:0] RND_HALF = AW'(32'sd536870912);

    // Arctangent of 2^-i in 1/2^32 turn.
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12e4051d;
            5'd2:  a = 32'h09fb385b;
            5'd3:  a = 32'h051111d4;
            5'd4:  a = 32'h028b0d43;
            5'd5:  a = 32'h0145d7e1;
            5'd6:  a = 32'h00a2f61e;
            5'd7:  a = 32'h00517c55;
            5'd8:  a = 32'h0028be53;
            5'd9:  a = 32'h00145f2e;
            5'd10: a = 32'h000a2f98;
            5'd11: a = 32'h000517cc;
            5'd12: a = 32'h00028be6;
            5'd13: a = 32'h000145f3;
            5'd14: a = 32'h0000a2f9;
            5'd15: a = 32'h0000517c;
            5'd16: a = 32'h000028be;
            5'd17: a = 32'h0000145f;
            5'd18: a = 32'h00000a2f;
            5'd19: a = 32'h00000517;
            5'd20: a = 32'h0000028b;
            5'd21: a = 32'h00000145;
            5'd22: a = 32'h000000a2;
            5'd23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

    // Plate step k as a fraction of a turn, rounded.
    function automatic logic [31:0] plate_step(input int k);
        logic [63:0] num;
        num = (64'(k) << 32) + 64'(PLATE_COUNT / 2);
        return 32'(num / PLATE_COUNT);
    endfunction

    // Rotation-mode CORDIC, evaluated at elaboration for the plate angles.
    function automatic logic [63:0] sin_cos(input logic [31:0] z_in);
        logic [31:0] z;
        logic [31:0] t;
        logic        neg;
        longint      x;
        longint      y;
        longint      zs;
        longint      xn;
        z = z_in;
        t = z + 32'h40000000;
        neg = t[31];
        if (neg)
        begin
            z = z + 32'h80000000;
        end
        zs = longint'($signed(z));
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (zs >= 0)
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                zs = zs - longint'(atan_turn(ITER_W'(i)));
            end
            else
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                zs = zs + longint'(atan_turn(ITER_W'(i)));
            end
            x = xn;
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        return {x[31:0], y[31:0]};
    endfunction

    // Round a Q30 product sum half away from zero and saturate to a coordinate.
    function automatic logic signed [C-1:0] rnd_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        if (v >= 0)
        begin
            t = (v + RND_HALF) >>> 30;
        end
        else
        begin
            t = -((-v + RND_HALF) >>> 30);
        end
        if (t > AW'(CMAX))
        begin
            return CMAX;
        end
        else if (t < AW'(CMIN))
        begin
            return CMIN;
        end
        return t[C-1:0];
    endfunction

    // Cosine and sine of every plate step, both senses.
    logic [63:0] tab_pos [TAB_DEPTH];
    logic [63:0] tab_neg [TAB_DEPTH];
    for (genvar g = 0; g < TAB_DEPTH; g++)
    begin : g_tab
        assign tab_pos[g] = sin_cos(plate_step(g));
        assign tab_neg[g] = sin_cos(32'd0 - plate_step(g));
    end

    // State with reset.
    logic [1:0]              dir_reg;
    logic [PIDX_W-1:0]       jo_reg;
    logic                    hv_reg;
    logic signed [AN-1:0]    ua_reg;
    logic                    seen_reg;

    // Working registers.
    logic                    req_reg;
    logic signed [C-1:0]     sx_reg, sy_reg, px_reg, py_reg, cx_reg, cy_reg, nx_reg;
    logic [14:0]             r_reg;
    logic [29:0]             rr_reg;
    logic signed [31:0]      coef_c_reg, coef_s_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [AW-1:0]    acc_reg, best_d_reg;
    logic [PIDX_W-1:0]       best_i_reg;
    logic signed [C:0]       dx_reg, dy_reg;
    logic signed [VW-1:0]    vx_reg, vy_reg;
    logic [31:0]             vz_reg;
    logic                    vzero_reg;
    logic signed [AN-1:0]    res_angle_reg;
    logic [2:0]              res_off_reg;
    logic                    res_seen_reg;

    // Combinational values.
    logic signed [C:0]       mul_a;
    logic signed [31:0]      mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [C-1:0]     src_x, src_y, ref_x, ref_y;
    logic signed [C-1:0]     rot_res;
    logic signed [AW-1:0]    rr_ext;
    logic                    over;
    logic [PIDX_W:0]         jo_sum;
    logic [PIDX_W-1:0]       jo_mod;
    logic signed [VW-1:0]    sx_ext, sy_ext, vx_sh, vy_sh;
    logic [31:0]             vz_round;
    logic [15:0]             ph16, d16;
    logic signed [AN:0]      usum;
    logic signed [AN-1:0]    ua_unwrap;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        src_x = cmd.rot_src_prev ? px_reg : sx_reg;
        src_y = cmd.rot_src_prev ? py_reg : sy_reg;
        ref_x = cmd.ref_cand ? cx_reg : px_reg;
        ref_y = cmd.ref_cand ? cy_reg : py_reg;
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_ROT0:
            begin
                mul_a = (C+1)'(src_x);
                mul_b = coef_c_reg;
            end
            OP_ROT1:
            begin
                mul_a = (C+1)'(src_y);
                mul_b = coef_s_reg;
            end
            OP_ROT2:
            begin
                mul_a = (C+1)'(src_x);
                mul_b = coef_s_reg;
            end
            OP_ROT3:
            begin
                mul_a = (C+1)'(src_y);
                mul_b = coef_c_reg;
            end
            OP_SQ0:
            begin
                mul_a = dx_reg;
                mul_b = 32'(dx_reg);
            end
            OP_SQ1:
            begin
                mul_a = dy_reg;
                mul_b = 32'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign rot_res = rnd_sat(acc_reg);

    // Jump threshold and plate offset arithmetic.
    assign rr_ext = AW'(rr_reg);
    assign over = acc_reg > rr_ext;
    assign jo_sum = {1'b0, jo_reg} + {1'b0, best_i_reg};
    assign jo_mod = (jo_sum >= (PIDX_W+1)'(PLATE_COUNT)) ?
                    PIDX_W'(jo_sum - (PIDX_W+1)'(PLATE_COUNT)) : jo_sum[PIDX_W-1:0];

    // Vectoring CORDIC step and phase unwrap.
    assign sx_ext = VW'(sx_reg) <<< 8;
    assign sy_ext = VW'(sy_reg) <<< 8;
    assign vx_sh = vx_reg >>> cmd.iter;
    assign vy_sh = vy_reg >>> cmd.iter;
    assign vz_round = vz_reg + 32'h00008000;
    assign ph16 = vzero_reg ? 16'h0000 : vz_round[31:16];
    assign d16 = ph16 - ua_reg[15:0];
    assign usum = (AN+1)'(ua_reg) + (AN+1)'($signed(d16));

    always_comb
    begin
        if (usum > (AN+1)'(AMAX))
        begin
            ua_unwrap = AMAX;
        end
        else if (usum < (AN+1)'(AMIN))
        begin
            ua_unwrap = AMIN;
        end
        else
        begin
            ua_unwrap = usum[AN-1:0];
        end
    end

    // Tracking state, direction register and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= '0;
            jo_reg   <= '0;
            hv_reg   <= 1'b0;
            ua_reg   <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:    seen_reg <= 1'b0;
                OP_THR:     seen_reg <= over;
                OP_OFS:     jo_reg <= jo_mod;
                OP_UNWRAP:
                begin
                    hv_reg <= 1'b1;
                    if (cmd.first)
                    begin
                        ua_reg <= AN'($signed(ph16));
                    end
                    else
                    begin
                        ua_reg <= ua_unwrap;
                    end
                end
                OP_RESTART:
                begin
                    hv_reg   <= 1'b0;
                    jo_reg   <= '0;
                    ua_reg   <= '0;
                    seen_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
            // A changed direction drops the plate offset.
            if (cfg_wr_en)
            begin
                if (cfg_wr_data != dir_reg)
                begin
                    jo_reg <= '0;
                end
                dir_reg <= cfg_wr_data;
            end
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_reg <= req_type;
                sx_reg  <= pos_x;
                sy_reg  <= pos_y;
                r_reg   <= jump_radius;
            end
            OP_COEF:
            begin
                if (cmd.coef_neg)
                begin
                    coef_c_reg <= tab_neg[cmd.k][63:32];
                    coef_s_reg <= tab_neg[cmd.k][31:0];
                end
                else
                begin
                    coef_c_reg <= tab_pos[cmd.k][63:32];
                    coef_s_reg <= tab_pos[cmd.k][31:0];
                end
            end
            OP_ROT1: acc_reg <= AW'(prod_reg);
            OP_ROT2: acc_reg <= acc_reg - AW'(prod_reg);
            OP_ROT3:
            begin
                nx_reg  <= rot_res;
                acc_reg <= AW'(prod_reg);
            end
            OP_ROT4: acc_reg <= acc_reg + AW'(prod_reg);
            OP_ROT5:
            begin
                if (cmd.rot_dst_cand)
                begin
                    cx_reg <= nx_reg;
                    cy_reg <= rot_res;
                end
                else
                begin
                    sx_reg <= nx_reg;
                    sy_reg <= rot_res;
                end
            end
            OP_DIF:
            begin
                dx_reg <= (C+1)'(sx_reg) - (C+1)'(ref_x);
                dy_reg <= (C+1)'(sy_reg) - (C+1)'(ref_y);
                rr_reg <= r_reg * r_reg;
            end
            OP_SQ1: acc_reg <= AW'(prod_reg);
            OP_SQ2: acc_reg <= acc_reg + AW'(prod_reg);
            OP_BEST:
            begin
                if (cmd.k == '0 || acc_reg < best_d_reg)
                begin
                    best_d_reg <= acc_reg;
                    best_i_reg <= cmd.k;
                end
            end
            OP_VINIT:
            begin
                vzero_reg <= (sx_reg == '0) && (sy_reg == '0);
                if (sx_reg < 0)
                begin
                    vx_reg <= -sx_ext;
                    vy_reg <= -sy_ext;
                    vz_reg <= 32'h80000000;
                end
                else
                begin
                    vx_reg <= sx_ext;
                    vy_reg <= sy_ext;
                    vz_reg <= 32'h0;
                end
            end
            OP_VSTEP:
            begin
                if (vy_reg > 0)
                begin
                    vx_reg <= vx_reg + vy_sh;
                    vy_reg <= vy_reg - vx_sh;
                    vz_reg <= vz_reg + atan_turn(cmd.iter);
                end
                else
                begin
                    vx_reg <= vx_reg - vy_sh;
                    vy_reg <= vy_reg + vx_sh;
                    vz_reg <= vz_reg - atan_turn(cmd.iter);
                end
            end
            OP_UNWRAP:
            begin
                px_reg <= sx_reg;
                py_reg <= sy_reg;
            end
            OP_RESTART:
            begin
                px_reg <= '0;
                py_reg <= '0;
            end
            OP_EMIT:
            begin
                res_angle_reg <= ua_reg;
                res_off_reg   <= 3'(jo_reg);
                res_seen_reg  <= seen_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        status.req_restart = req_reg;
        status.hist_valid  = hv_reg;
        status.dir_active  = (dir_reg == 2'd1) || (dir_reg == 2'd2);
        status.dir_cw      = (dir_reg == 2'd1);
        status.offset_nz   = (jo_reg != '0);
        status.jump        = over;
        status.offset      = jo_reg;
        status.best        = best_i_reg;
    end

    assign track_angle  = res_angle_reg;
    assign plate_offset = res_off_reg;
    assign jump_seen    = res_seen_reg;

endmodule

@@ hw/rtl/tat_ctrl.sv @@
// Controller state machine that sequences the tracker datapath.
module tat_ctrl #(
    parameter int PLATE_COUNT = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tat_pkg::dp_status_t status,
    output tat_pkg::dp_cmd_t    cmd
);
    import tat_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_COEF   = 4'd2;
    localparam logic [3:0] S_ROT    = 4'd3;
    localparam logic [3:0] S_DIF    = 4'd4;
    localparam logic [3:0] S_SQ     = 4'd5;
    localparam logic [3:0] S_THR    = 4'd6;
    localparam logic [3:0] S_BEST   = 4'd7;
    localparam logic [3:0] S_OFS    = 4'd8;
    localparam logic [3:0] S_VINIT  = 4'd9;
    localparam logic [3:0] S_VSTEP  = 4'd10;
    localparam logic [3:0] S_UNWRAP = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_CAND  = 2'd1;
    localparam logic [1:0] MODE_FINAL = 2'd2;

    localparam logic [ITER_W-1:0] ROT_LAST = ITER_W'(5);
    localparam logic [ITER_W-1:0] SQ_LAST  = ITER_W'(2);
    localparam logic [ITER_W-1:0] VEC_LAST = ITER_W'(CORDIC_STEPS - 1);
    localparam logic [PIDX_W-1:0] CAND_LAST = PIDX_W'(PLATE_COUNT - 1);

    logic [3:0]         state_reg, state_next;
    logic [ITER_W-1:0]  cnt_reg, cnt_next;
    logic [PIDX_W-1:0]  cand_reg, cand_next;
    logic [1:0]         mode_reg, mode_next;
    logic               first_reg, first_next;
    logic               out_valid_reg, out_valid_next;

    // Next state and datapath command.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cand_next      = cand_reg;
        mode_next      = mode_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd.op           = OP_NOP;
        cmd.rot_src_prev = (mode_reg == MODE_CAND);
        cmd.rot_dst_cand = (mode_reg == MODE_CAND);
        cmd.ref_cand     = (mode_reg == MODE_CAND);
        cmd.iter         = cnt_reg;
        cmd.first        = first_reg;
        unique case (mode_reg)
            MODE_CAND:
            begin
                cmd.k        = cand_reg;
                cmd.coef_neg = !status.dir_cw;
            end
            MODE_FINAL:
            begin
                cmd.k        = status.best;
                cmd.coef_neg = status.dir_cw;
            end
            default:
            begin
                cmd.k        = status.offset;
                cmd.coef_neg = status.dir_cw;
            end
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cnt_next  = '0;
                mode_next = MODE_INIT;
                priority if (status.req_restart)
                begin
                    cmd.op     = OP_RESTART;
                    state_next = S_EMIT;
                end
                else if (!status.hist_valid)
                begin
                    first_next = 1'b1;
                    state_next = S_VINIT;
                end
                else if (status.dir_active)
                begin
                    first_next = 1'b0;
                    state_next = status.offset_nz ? S_COEF : S_DIF;
                end
                else
                begin
                    first_next = 1'b0;
                    state_next = S_VINIT;
                end
            end
            S_COEF:
            begin
                cmd.op     = OP_COEF;
                cnt_next   = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.op = dp_op_t'(OP_ROT0 + dp_op_t'(cnt_reg));
                if (cnt_reg == ROT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (mode_reg == MODE_FINAL) ? S_VINIT : S_DIF;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIF:
            begin
                cmd.op     = OP_DIF;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = dp_op_t'(OP_SQ0 + dp_op_t'(cnt_reg));
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (mode_reg == MODE_CAND) ? S_BEST : S_THR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_THR:
            begin
                cmd.op = OP_THR;
                if (status.jump)
                begin
                    mode_next  = MODE_CAND;
                    cand_next  = '0;
                    state_next = S_COEF;
                end
                else
                begin
                    state_next = S_VINIT;
                end
            end
            S_BEST:
            begin
                cmd.op = OP_BEST;
                if (cand_reg == CAND_LAST)
                begin
                    state_next = S_OFS;
                end
                else
                begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = S_COEF;
                end
            end
            S_OFS:
            begin
                cmd.op = OP_OFS;
                if (status.best != '0)
                begin
                    mode_next  = MODE_FINAL;
                    state_next = S_COEF;
                end
                else
                begin
                    state_next = S_VINIT;
                end
            end
            S_VINIT:
            begin
                cmd.op     = OP_VINIT;
                cnt_next   = '0;
                state_next = S_VSTEP;
            end
            S_VSTEP:
            begin
                cmd.op = OP_VSTEP;
                if (cnt_reg == VEC_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_UNWRAP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UNWRAP:
            begin
                cmd.op     = OP_UNWRAP;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cand_reg      <= '0;
            mode_reg      <= MODE_INIT;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cand_reg      <= cand_next;
            mode_reg      <= mode_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/symmetric_target_angle_tracker.sv @@
// Top level of the symmetric target angle tracker.
//
// Usage: each request word on req carries a sample (pos_x, pos_y relative to
// the rotation center, jump_radius) or, with req_type set, a restart. Every
// request word yields exactly one result word on res: the unwrapped angle in
// 1/65536 turn, the plate offset and the jump flag.
// The rotation direction is set through cfg_wr_en/cfg_wr_data while idle.
// One word is processed at a time. A restart only clears the history; every
// sample runs the 24-step vectoring CORDIC and the unwrap, which dominate. A
// tracked sample first has its distance to the previous point checked.
// Applying a plate offset adds a rotation, a jump adds a rotation and a
// distance for every plate, and correcting onto a rotated copy adds one more
// rotation, since every rotation and distance runs through the single shared
// multiplier. The next request word can be taken in the cycle res.valid rises.
// The output register lets the next request word be accepted while a result
// waits; if the receiver stalls, the following result holds in the datapath
// and no further request word is taken until the output register frees.
// Reset clears the history, offset, angle and direction; no result is pending.
module symmetric_target_angle_tracker #(
    parameter int PLATE_COUNT = 5,
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    tat_req_if.sink    req,
    tat_res_if.source  res
);
    import tat_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tat_ctrl #(
        .PLATE_COUNT (PLATE_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tat_datapath #(
        .PLATE_COUNT (PLATE_COUNT),
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (req.req_type),
        .pos_x        (req.pos_x),
        .pos_y        (req.pos_y),
        .jump_radius  (req.jump_radius),
        .track_angle  (res.track_angle),
        .plate_offset (res.plate_offset),
        .jump_seen    (res.jump_seen)
    );

    // The block is busy right after it takes a request word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted on two consecutive cycles");

    // A reported plate offset stays below the plate count.
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ({1'b0, res.plate_offset} < 4'(PLATE_COUNT)))
        else $error("plate offset out of range");

    // A jump is only reported with a known rotation direction.
    a_jump_needs_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.jump_seen) |-> status.dir_active)
        else $error("jump reported with unknown direction");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the symmetric target angle tracker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLATES = 5;
    localparam int STEPS = 24;
    localparam longint GAIN_Q30 = 652032874;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD = 400;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 178;
    localparam real TWO_PI = 6.283185307179586;

    localparam bit [1:0] DIR_UNKNOWN = 2'd0;
    localparam bit [1:0] DIR_CW = 2'd1;
    localparam bit [1:0] DIR_ACW = 2'd2;
    localparam bit [1:0] DIR_SPARE = 2'd3;
    localparam bit REQ_SAMPLE = 1'b0;
    localparam bit REQ_RESTART = 1'b1;

    localparam int unsigned ARC_TURN [STEPS] = '{
        32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4, 32'h028b0d43,
        32'h0145d7e1, 32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2e,
        32'h000a2f98, 32'h000517cc, 32'h00028be6, 32'h000145f3, 32'h0000a2f9,
        32'h0000517c, 32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
        32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
    };

    typedef struct packed {
        logic        req_type;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [14:0] jump_radius;
    } sample_word_t;

    typedef struct packed {
        logic signed [31:0] track_angle;
        logic [2:0]         plate_offset;
        logic               jump_seen;
    } angle_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;

    tat_req_if #(.COORD_WIDTH(16)) req ();
    tat_res_if #(.ANGLE_WIDTH(32)) res ();

    symmetric_target_angle_tracker #(
        .PLATE_COUNT(PLATES),
        .COORD_WIDTH(16),
        .ANGLE_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req(req.sink),
        .res(res.source)
    );

    always #5 clk = ~clk;

    sample_word_t pending_words[$];
    angle_word_t expected_angles[$];
    int errors = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_request = 1'b0;
    bit req_fire = 1'b0;

    // Tracker state mirrored by the predictor
    bit [1:0] trk_dir = DIR_UNKNOWN;
    longint trk_px = 0;
    longint trk_py = 0;
    bit trk_valid = 1'b0;
    int trk_offset = 0;
    longint trk_angle = 0;

    // Append one word to the stimulus queue
    function automatic void queue_word(sample_word_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic longint round30(longint v);
        if (v >= 0)
            return (v + (64'sd1 <<< 29)) >>> 30;
        return -(((-v) + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic longint clamp16(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic int unsigned plate_angle(int k);
        longint unsigned num;
        num = (longint'(k) << 32) + PLATES / 2;
        return int'(num / PLATES);
    endfunction

    function automatic void turn_point(int unsigned ang, ref longint x, ref longint y);
        bit neg;
        int unsigned z;
        longint cx, sy, zs, xn, nx, ny;
        z = ang;
        cx = GAIN_Q30;
        sy = 0;
        neg = ((z + 32'h40000000) & 32'h80000000) != 0;
        if (neg)
            z = z + 32'h80000000;
        zs = longint'($signed(z));
        for (int i = 0; i < STEPS; i++)
        begin
            if (zs >= 0)
            begin
                xn = cx - (sy >>> i);
                sy = sy + (cx >>> i);
                zs -= ARC_TURN[i];
            end
            else
            begin
                xn = cx + (sy >>> i);
                sy = sy - (cx >>> i);
                zs += ARC_TURN[i];
            end
            cx = xn;
        end
        if (neg)
        begin
            cx = -cx;
            sy = -sy;
        end
        nx = round30(x * cx - y * sy);
        ny = round30(x * sy + y * cx);
        x = clamp16(nx);
        y = clamp16(ny);
    endfunction

    function automatic int unsigned phase_of(longint x0, longint y0);
        longint x, y, xn;
        int unsigned z;
        x = x0 * 256;
        y = y0 * 256;
        z = 0;
        if (x0 == 0 && y0 == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += ARC_TURN[i];
            end
            else
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= ARC_TURN[i];
            end
            x = xn;
        end
        return (z + 32'h8000) >> 16;
    endfunction

    function automatic void unwrap_phase(int unsigned ph);
        longint d, sum;
        d = longint'((ph - int'(trk_angle[15:0])) & 32'hFFFF);
        if (d >= 32'h8000)
            d -= 32'h10000;
        sum = trk_angle + d;
        trk_angle = sum > 64'sd2147483647 ? 64'sd2147483647 :
                    (sum < -64'sd2147483648 ? -64'sd2147483648 : sum);
    endfunction

    // Work out the result word for one accepted sample word
    function automatic angle_word_t track_word(sample_word_t w);
        angle_word_t o;
        longint x, y, r, dx, dy, cx, cy, d, bestd;
        int best;
        bit cw, seen;
        int unsigned ph, a;
        seen = 1'b0;
        if (w.req_type == REQ_RESTART)
        begin
            trk_valid = 1'b0;
            trk_px = 0;
            trk_py = 0;
            trk_offset = 0;
            trk_angle = 0;
            return '0;
        end
        x = longint'($signed(w.pos_x));
        y = longint'($signed(w.pos_y));
        r = longint'(w.jump_radius);
        if (!trk_valid)
        begin
            ph = phase_of(x, y);
            trk_angle = longint'($signed(ph[15:0]));
            trk_valid = 1'b1;
        end
        else if (trk_dir == DIR_CW || trk_dir == DIR_ACW)
        begin
            cw = trk_dir == DIR_CW;
            if (trk_offset != 0)
            begin
                a = plate_angle(trk_offset);
                turn_point(cw ? 0 - a : a, x, y);
            end
            dx = x - trk_px;
            dy = y - trk_py;
            if (dx * dx + dy * dy > r * r)
            begin
                seen = 1'b1;
                best = 0;
                bestd = 0;
                for (int i = 0; i < PLATES; i++)
                begin
                    cx = trk_px;
                    cy = trk_py;
                    a = plate_angle(i);
                    turn_point(cw ? a : 0 - a, cx, cy);
                    d = (x - cx) * (x - cx) + (y - cy) * (y - cy);
                    if (i == 0 || d < bestd)
                    begin
                        bestd = d;
                        best = i;
                    end
                end
                if (best != 0)
                begin
                    a = plate_angle(best);
                    turn_point(cw ? 0 - a : a, x, y);
                end
                trk_offset = (trk_offset + best) % PLATES;
            end
            unwrap_phase(phase_of(x, y));
        end
        else
            unwrap_phase(phase_of(x, y));
        trk_px = x;
        trk_py = y;
        o.track_angle = trk_angle[31:0];
        o.plate_offset = trk_offset[2:0];
        o.jump_seen = seen;
        return o;
    endfunction

    // Request driver: new word or idle at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.req_type <= REQ_SAMPLE;
            req.pos_x <= '0;
            req.pos_y <= '0;
            req.jump_radius <= '0;
        end
        else if (req.valid && !req_fire)
            req.valid <= 1'b1;
        else if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct)
        begin
            sample_word_t w;
            w = pending_words.pop_front();
            req.req_type <= w.req_type;
            req.pos_x <= w.pos_x;
            req.pos_y <= w.pos_y;
            req.jump_radius <= w.jump_radius;
            req.valid <= 1'b1;
        end
        else
            req.valid <= 1'b0;
    end

    // Result ready, with a single long hold-off
    int hold_left = 0;
    bit hold_seen = 1'b0;
    always @(negedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_request && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= LONG_HOLD;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Accepted request words feed the predictor; result words are checked
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        req_fire <= req.valid && req.ready && rst_n;
        if (rst_n && req.valid && req.ready)
            expected_angles.insert(expected_angles.size(),
                                   track_word({req.req_type, req.pos_x,
                                               req.pos_y, req.jump_radius}));
        if (rst_n && res.valid && res.ready)
        begin
            angle_word_t e;
            if (expected_angles.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_angles.pop_front();
                if (res.track_angle !== e.track_angle)
                begin
                    $error("track_angle expected %0d got %0d",
                           e.track_angle, res.track_angle);
                    errors++;
                end
                if (res.plate_offset !== e.plate_offset)
                begin
                    $error("plate_offset expected %0d got %0d",
                           e.plate_offset, res.plate_offset);
                    errors++;
                end
                if (res.jump_seen !== e.jump_seen)
                begin
                    $error("jump_seen expected %0d got %0d", e.jump_seen, res.jump_seen);
                    errors++;
                end
            end
        end
        if ((req.valid && req.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic sample_word_t make_word(bit kind, longint x, longint y, longint r);
        sample_word_t w;
        w.req_type = kind;
        w.pos_x = 16'(clamp16(x));
        w.pos_y = 16'(clamp16(y));
        w.jump_radius = 15'(r < 0 ? 0 : (r > 32767 ? 32767 : r));
        return w;
    endfunction

    // A target moving on a circle, now and then seen on another plate, mixed with random samples and restarts
    task automatic queue_track(int n);
        real rad, theta, dtheta;
        int plate, jr;
        rad = real'($urandom_range(30000, 100));
        theta = real'($urandom_range(999)) * TWO_PI / 1000.0;
        dtheta = (real'($urandom_range(400)) - 200.0) / 1000.0;
        plate = 0;
        jr = int'(rad * real'($urandom_range(60, 5)) / 100.0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 12)
                plate = (plate + $urandom_range(4, 1)) % PLATES;
            theta += dtheta;
            if ($urandom_range(99) < 4)
                queue_word(make_word(REQ_SAMPLE, $signed($urandom()),
                                     $signed($urandom()), $urandom_range(32767)));
            else if ($urandom_range(99) < 2)
                queue_word(make_word(REQ_RESTART, $signed($urandom()),
                                     $signed($urandom()), $urandom_range(32767)));
            else
                queue_word(make_word(REQ_SAMPLE,
                    $rtoi(rad * $cos(theta + plate * TWO_PI / PLATES)),
                    $rtoi(rad * $sin(theta + plate * TWO_PI / PLATES)), jr));
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || expected_angles.size() > 0 || req.valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(bit [1:0] dir);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= dir;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (dir != trk_dir)
            trk_offset = 0;
        trk_dir = dir;
    endtask

    bit [1:0] phase_dir [PHASES] = '{DIR_UNKNOWN, DIR_CW, DIR_ACW, DIR_SPARE,
                                      DIR_CW, DIR_CW, DIR_ACW, DIR_UNKNOWN};

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: extremes, origin, half turn, restart
        queue_word(make_word(REQ_RESTART, 0, 0, 0));
        queue_word(make_word(REQ_SAMPLE, 32767, -32768, 32767));
        queue_word(make_word(REQ_SAMPLE, 0, 0, 0));
        queue_word(make_word(REQ_SAMPLE, -32768, 32767, 0));
        queue_word(make_word(REQ_SAMPLE, -32768, 0, 0));
        queue_word(make_word(REQ_SAMPLE, 32767, 0, 0));
        queue_word(make_word(REQ_SAMPLE, -32768, -32768, 32767));
        queue_word(make_word(REQ_RESTART, -1, -1, 32767));
        queue_word(make_word(REQ_SAMPLE, 0, 0, 0));
        queue_word(make_word(REQ_SAMPLE, 1, -1, 1));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_direction(phase_dir[p]);
            if (p < 3)
            begin
                src_idle_pct = 35;
                snk_idle_pct = 59;
            end
            else if (p < 6)
            begin
                src_idle_pct = 59;
                snk_idle_pct = 35;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (p == 1)
            begin
                // Plate jump seen right away, then corrected back
                queue_word(make_word(REQ_SAMPLE, 8000, 0, 50));
                queue_word(make_word(REQ_SAMPLE, 2472, 7608, 50));
                queue_word(make_word(REQ_SAMPLE, 2480, 7600, 50));
                queue_word(make_word(REQ_SAMPLE, 8000, 10, 32767));
            end
            if (p == 4)
                hold_request = 1'b1;
            while (pending_words.size() < WORDS_PER_PHASE)
                queue_track($urandom_range(40, 8));
        end
        wait_idle();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
